### rtl/core/nrf_pkg.sv
// ----------------------------------------------------------------------------
// Newton root finder package
// Widths, register indexes, operation and status codes, and default
// configuration values shared by the root finder files.
// ----------------------------------------------------------------------------
package nrf_pkg;

    // Q16.16 fixed point values.
    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 16;

    // Field widths of the input and result words.
    localparam int OP_W     = 1;
    localparam int INDEX_W  = 4;
    localparam int STEPS_W  = 16;
    localparam int STATUS_W = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DEGREE_W    = 4;
    localparam int LIMIT_W     = 16;
    localparam int TOL_W       = 16;

    // Divider: the dividend is |f| scaled by 2^16.
    localparam int DIVIDEND_W = VALUE_W + FRAC_W;
    localparam int DIVISOR_W  = VALUE_W;

    // Largest polynomial degree held in the coefficient store.
    localparam int MAX_DEGREE_DEF = 15;

    // Reset values of the configuration registers.
    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd1;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd100;
    localparam logic [TOL_W-1:0]    TOL_RESET    = 16'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POLY_DEGREE = 2'd0,
        CFG_ITER_LIMIT  = 2'd1,
        CFG_TOLERANCE   = 2'd2
    } cfg_reg_t;

    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_SOLVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_CONVERGED  = 2'd0,
        ST_LIMIT      = 2'd1,
        ST_ZERO_DERIV = 2'd2
    } status_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } nrf_div_stat_t;

endpackage

### rtl/core/nrf_if.sv
// ----------------------------------------------------------------------------
// Newton root finder channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface nrf_in_if;
    logic                                valid;
    logic                                ready;
    logic [nrf_pkg::OP_W-1:0]            op;
    logic [nrf_pkg::INDEX_W-1:0]         coef_index;
    logic signed [nrf_pkg::VALUE_W-1:0]  coef_value;
    logic signed [nrf_pkg::VALUE_W-1:0]  start_guess;

    modport source (output valid, op, coef_index, coef_value, start_guess, input ready);
    modport sink   (input valid, op, coef_index, coef_value, start_guess, output ready);
endinterface

interface nrf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [nrf_pkg::VALUE_W-1:0]  root;
    logic [nrf_pkg::STEPS_W-1:0]         steps_used;
    logic [nrf_pkg::STATUS_W-1:0]        status;

    modport source (output valid, root, steps_used, status, input ready);
    modport sink   (input valid, root, steps_used, status, output ready);
endinterface

### rtl/core/polynomial_newton_root_finder_core.sv
// ----------------------------------------------------------------------------
// Polynomial Newton root finder core
// Loads polynomial coefficients into a small store and, for each solve word,
// runs Newton-Raphson steps in signed Q16.16 until convergence, the step
// limit or a zero derivative, then returns one result word.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word contents                                   Results
// -------   ---------  ----------------------------------------------  -------
// in_ch     in         op, coef_index, coef_value, start_guess          0 or 1
// out_ch    out        root, steps_used, status                         -
// cfg_*     in         cfg_we, cfg_index, cfg_wdata (no handshake)      -
//
// A load word is written into the store as it is accepted. A solve word
// runs a number of Newton steps, each made of a Horner pass (one shared
// multiplier, two products per coefficient plus the store read), a check
// state, the serial divider and the update states S_QSAT, S_UPD and S_CONV,
// with S_IDLE to start and S_OUT to finish. The divider loop dominates.
// Reset clears the coefficient store through per-entry valid bits, so no
// clearing pass is needed. Input is taken only between solves; a finished
// result waits in the output register, and the next word is accepted while
// it waits.
//
module polynomial_newton_root_finder_core #(
    parameter int MAX_DEGREE = nrf_pkg::MAX_DEGREE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    nrf_in_if.sink                             in_ch,
    nrf_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [nrf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nrf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import nrf_pkg::*;

    // Address width of the coefficient store.
    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int CW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_D,
        S_ACC_D,
        S_ACC_F,
        S_CHECK,
        S_DIV,
        S_QSAT,
        S_UPD,
        S_CONV,
        S_OUT
    } state_t;

    // Saturate a 34-bit sum to the signed 32-bit range.
    function automatic logic signed [VALUE_W-1:0] sat34(input logic signed [VALUE_W+1:0] v);
        logic signed [VALUE_W-1:0] r;
        begin
            if (v > 34'sh0_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -34'sh0_8000_0000)
                r = 32'sh8000_0000;
            else
                r = v[VALUE_W-1:0];
            return r;
        end
    endfunction

    // Round a raw Q32.32 product to Q16.16 (ties toward plus infinity) and
    // saturate.
    function automatic logic signed [VALUE_W-1:0] qround(input logic signed [2*VALUE_W-1:0] p);
        logic signed [2*VALUE_W-1:0] r;
        logic signed [VALUE_W-1:0]   q;
        begin
            r = (p + 64'sd32768) >>> FRAC_W;
            if (r > 64'sh0000_0000_7FFF_FFFF)
                q = 32'sh7FFF_FFFF;
            else if (r < 64'shFFFF_FFFF_8000_0000)
                q = 32'sh8000_0000;
            else
                q = r[VALUE_W-1:0];
            return q;
        end
    endfunction

    // Saturating Q16.16 add.
    function automatic logic signed [VALUE_W-1:0] qadd(input logic signed [VALUE_W-1:0] a,
                                                       input logic signed [VALUE_W-1:0] b);
        logic signed [VALUE_W+1:0] s;
        begin
            s = {{2{a[VALUE_W-1]}}, a} + {{2{b[VALUE_W-1]}}, b};
            return sat34(s);
        end
    endfunction

    // Configuration registers.
    logic [DEGREE_W-1:0]           poly_degree_reg;
    logic [LIMIT_W-1:0]            iter_limit_reg;
    logic [TOL_W-1:0]              tolerance_reg;

    // Sequencer state.
    state_t                        state_reg, state_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 deg_reg, deg_next;
    logic signed [VALUE_W-1:0]     x_reg, x_next;
    logic signed [VALUE_W-1:0]     xold_reg, xold_next;
    logic signed [VALUE_W-1:0]     f_reg, f_next;
    logic signed [VALUE_W-1:0]     d_reg, d_next;
    logic signed [2*VALUE_W-1:0]   prod_reg, prod_next;
    logic signed [VALUE_W-1:0]     q_reg, q_next;
    logic                          neg_reg, neg_next;
    logic [STEPS_W-1:0]            steps_reg, steps_next;
    status_t                       status_reg, status_next;
    logic [DEPTH-1:0]              valid_reg, valid_next;

    // Result register.
    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0]     out_root_reg, out_root_next;
    logic [STEPS_W-1:0]            out_steps_reg, out_steps_next;
    status_t                       out_status_reg, out_status_next;

    // Coefficient store with a registered read.
    logic signed [VALUE_W-1:0]     coef_mem [DEPTH];
    logic signed [VALUE_W-1:0]     mem_q_reg;
    logic                          mem_vld_reg;
    logic signed [VALUE_W-1:0]     coef;

    logic                          in_accept;
    logic                          load_en;
    logic signed [VALUE_W-1:0]     mul_a;

    // Divider hookup.
    logic                          div_start;
    logic [DIVIDEND_W-1:0]         div_dividend;
    logic [DIVISOR_W-1:0]          div_divisor;
    logic [DIVIDEND_W-1:0]         div_quotient;
    nrf_div_stat_t                 div_stat;

    // Update path.
    logic signed [VALUE_W+1:0]     x_diff;
    logic [VALUE_W+1:0]            x_step;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign load_en     = in_accept && (in_ch.op == OP_LOAD)
                         && (int'(in_ch.coef_index) <= MAX_DEGREE);

    // An entry never written since reset reads as zero.
    assign coef = mem_vld_reg ? mem_q_reg : '0;

    // The single multiplier takes d*x in S_MUL_D and f*x in S_ACC_D.
    assign mul_a     = (state_reg == S_MUL_D) ? d_reg : f_reg;
    assign prod_next = mul_a * x_reg;

    // The divider works on magnitudes; the sign is restored afterwards.
    assign div_start    = (state_reg == S_CHECK) && (d_reg != '0);
    assign div_dividend = {(f_reg[VALUE_W-1] ? -f_reg : f_reg), {FRAC_W{1'b0}}};
    assign div_divisor  = d_reg[VALUE_W-1] ? -d_reg : d_reg;

    nrf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // Exact step size between the new and the previous estimate.
    assign x_diff = {{2{x_reg[VALUE_W-1]}}, x_reg} - {{2{xold_reg[VALUE_W-1]}}, xold_reg};
    assign x_step = x_diff[VALUE_W+1] ? -x_diff : x_diff;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        deg_next        = deg_reg;
        x_next          = x_reg;
        xold_next       = xold_reg;
        f_next          = f_reg;
        d_next          = d_reg;
        q_next          = q_reg;
        neg_next        = neg_reg;
        steps_next      = steps_reg;
        status_next     = status_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        out_root_next   = out_root_reg;
        out_steps_next  = out_steps_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load_en)
        begin
            valid_next[CW'(in_ch.coef_index)] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_ch.op == OP_SOLVE))
                begin
                    x_next     = in_ch.start_guess;
                    steps_next = '0;
                    idx_next   = '0;
                    f_next     = '0;
                    d_next     = '0;
                    if (int'(poly_degree_reg) > MAX_DEGREE)
                        deg_next = CW'(MAX_DEGREE);
                    else
                        deg_next = CW'(poly_degree_reg);
                    if (iter_limit_reg == '0)
                    begin
                        // No step allowed: report the guess as it stands.
                        status_next = ST_LIMIT;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL_D;
                    end
                end
            end
            S_MUL_D:
            begin
                state_next = S_ACC_D;
            end
            S_ACC_D:
            begin
                d_next     = qadd(qround(prod_reg), f_reg);
                state_next = S_ACC_F;
            end
            S_ACC_F:
            begin
                f_next = qadd(qround(prod_reg), coef);
                if (idx_reg == deg_reg)
                begin
                    steps_next = steps_reg + 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MUL_D;
                end
            end
            S_CHECK:
            begin
                neg_next = f_reg[VALUE_W-1] ^ d_reg[VALUE_W-1];
                if (d_reg == '0)
                begin
                    status_next = ST_ZERO_DERIV;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_QSAT;
                end
            end
            S_QSAT:
            begin
                // Apply the sign and saturate the truncated quotient.
                if (neg_reg)
                begin
                    if (div_quotient > DIVIDEND_W'(64'h0000_0000_8000_0000))
                        q_next = 32'sh8000_0000;
                    else
                        q_next = -$signed(div_quotient[VALUE_W-1:0]);
                end
                else
                begin
                    if (div_quotient > DIVIDEND_W'(64'h0000_0000_7FFF_FFFF))
                        q_next = 32'sh7FFF_FFFF;
                    else
                        q_next = $signed(div_quotient[VALUE_W-1:0]);
                end
                state_next = S_UPD;
            end
            S_UPD:
            begin
                xold_next  = x_reg;
                x_next     = sat34({{2{x_reg[VALUE_W-1]}}, x_reg}
                                   - {{2{q_reg[VALUE_W-1]}}, q_reg});
                state_next = S_CONV;
            end
            S_CONV:
            begin
                if (x_step < {{(VALUE_W+2-TOL_W){1'b0}}, tolerance_reg})
                begin
                    status_next = ST_CONVERGED;
                    state_next  = S_OUT;
                end
                else if (steps_reg == iter_limit_reg)
                begin
                    status_next = ST_LIMIT;
                    state_next  = S_OUT;
                end
                else
                begin
                    idx_next   = '0;
                    f_next     = '0;
                    d_next     = '0;
                    state_next = S_MUL_D;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_root_next   = x_reg;
                    out_steps_next  = steps_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            x_reg          <= '0;
            steps_reg      <= '0;
            status_reg     <= ST_LIMIT;
            idx_reg        <= '0;
            deg_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            x_reg          <= x_next;
            steps_reg      <= steps_next;
            status_reg     <= status_next;
            idx_reg        <= idx_next;
            deg_reg        <= deg_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        xold_reg       <= xold_next;
        f_reg          <= f_next;
        d_reg          <= d_next;
        prod_reg       <= prod_next;
        q_reg          <= q_next;
        neg_reg        <= neg_next;
        out_root_reg   <= out_root_next;
        out_steps_reg  <= out_steps_next;
        out_status_reg <= out_status_next;
    end

    // Coefficient store: loads write only while idle, reads follow idx_reg.
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            coef_mem[CW'(in_ch.coef_index)] <= in_ch.coef_value;
        end
        mem_q_reg   <= coef_mem[idx_reg];
        mem_vld_reg <= valid_reg[idx_reg];
    end

    // Configuration writes; an index past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_degree_reg <= DEGREE_RESET;
            iter_limit_reg  <= LIMIT_RESET;
            tolerance_reg   <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLY_DEGREE: poly_degree_reg <= cfg_wdata[DEGREE_W-1:0];
                CFG_ITER_LIMIT:  iter_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                CFG_TOLERANCE:   tolerance_reg   <= cfg_wdata[TOL_W-1:0];
                default:         ;
            endcase
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.root       = out_root_reg;
    assign out_ch.steps_used = out_steps_reg;
    assign out_ch.status     = out_status_reg;

endmodule

### rtl/core/nrf_div.sv
// ----------------------------------------------------------------------------
// Newton root finder divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nrf_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [nrf_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [nrf_pkg::DIVISOR_W-1:0]       divisor,
    output logic [nrf_pkg::DIVIDEND_W-1:0]      quotient,
    output nrf_pkg::nrf_div_stat_t              stat
);
    import nrf_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIVIDEND_W - 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0]   quo_reg, quo_next;
    logic [DIVISOR_W-1:0]    dsr_reg, dsr_next;

    logic [DIVISOR_W:0]      shifted;
    logic [DIVISOR_W:0]      trial;
    logic                    fits;

    // The partial remainder stays below the divisor, so it fits in its width.
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### sim/nrf_result_checker.sv
// ----------------------------------------------------------------------------
// Newton root finder result checker
// Watches the command, result and configuration ports of the root finder,
// keeps its own coefficient store and register copies, works out the result
// of every accepted solve word and compares each result word with it.
// ----------------------------------------------------------------------------
module nrf_result_checker
    import nrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    nrf_in_if                      cmd,
    nrf_out_if                     res,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     error_count,
    output int                     pending_count,
    output int                     converged_count,
    output int                     limit_count,
    output int                     zero_deriv_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VALUE_W-1:0] root;
        logic [STEPS_W-1:0]        steps_used;
        status_t                   status;
    } root_result_t;

    logic signed [VALUE_W-1:0] coef_mem [MAX_DEGREE_DEF+1];
    logic [DEGREE_W-1:0]       degree_reg;
    logic [LIMIT_W-1:0]        limit_reg;
    logic [TOL_W-1:0]          tol_reg;
    root_result_t              pending_roots [$];

    function automatic logic signed [VALUE_W-1:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[VALUE_W-1:0];
    endfunction

    // Product rounded to nearest with ties upward; the arithmetic shift is a
    // floor division by 2^16.
    function automatic logic signed [VALUE_W-1:0] q16_mul(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clamp_q16(p >>> FRAC_W);
    endfunction

    function automatic root_result_t predict_root(input logic signed [VALUE_W-1:0] x0);
        root_result_t              r;
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] fv;
        logic signed [VALUE_W-1:0] dv;
        logic signed [VALUE_W-1:0] xn;
        longint                    diff;
        int unsigned               n;
        int unsigned               deg;
        int unsigned               i;
        logic                      done;
        x    = x0;
        n    = 0;
        done = 1'b0;
        r.status = ST_LIMIT;
        deg = (degree_reg > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : degree_reg;
        while (!done && n < limit_reg) begin
            fv = '0;
            dv = '0;
            // Horner pass evaluates the derivative and the value together.
            for (i = 0; i <= deg; i++) begin
                dv = clamp_q16(longint'(q16_mul(dv, x)) + longint'(fv));
                fv = clamp_q16(longint'(q16_mul(fv, x)) + longint'(coef_mem[i]));
            end
            n++;
            if (dv == 0) begin
                r.status = ST_ZERO_DERIV;
                done = 1'b1;
            end
            else begin
                xn = clamp_q16(longint'(x)
                     - longint'(clamp_q16((longint'(fv) <<< FRAC_W) / longint'(dv))));
                diff = longint'(xn) - longint'(x);
                if (diff < 0)
                    diff = -diff;
                x = xn;
                if (diff < longint'(tol_reg)) begin
                    r.status = ST_CONVERGED;
                    done = 1'b1;
                end
            end
        end
        r.root       = x;
        r.steps_used = n[STEPS_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        root_result_t want;
        if (!rst_n) begin
            foreach (coef_mem[k])
                coef_mem[k] = '0;
            degree_reg       = DEGREE_RESET;
            limit_reg        = LIMIT_RESET;
            tol_reg          = TOL_RESET;
            pending_roots.delete();
            error_count      = 0;
            pending_count    = 0;
            converged_count  = 0;
            limit_count      = 0;
            zero_deriv_count = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_POLY_DEGREE: degree_reg = cfg_wdata[DEGREE_W-1:0];
                    CFG_ITER_LIMIT:  limit_reg  = cfg_wdata[LIMIT_W-1:0];
                    CFG_TOLERANCE:   tol_reg    = cfg_wdata[TOL_W-1:0];
                    default: ;
                endcase
            end

            // Results are checked before new solves are queued, so a result
            // can never be matched against a solve accepted on the same edge.
            if (res.valid && res.ready) begin
                if (pending_roots.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result word root=%h steps=%0d status=%0d",
                                 $time, res.root, res.steps_used, res.status);
                end
                else begin
                    want = pending_roots.pop_front();
                    case (want.status)
                        ST_CONVERGED: converged_count++;
                        ST_LIMIT:     limit_count++;
                        default:      zero_deriv_count++;
                    endcase
                    if (res.root !== want.root || res.steps_used !== want.steps_used
                        || res.status !== want.status) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: result mismatch root %h/%h steps %0d/%0d %s %0d/%0d",
                                     $time, want.root, res.root, want.steps_used,
                                     res.steps_used, "status", want.status, res.status);
                    end
                end
            end

            if (cmd.valid && cmd.ready) begin
                // The index field cannot exceed the store depth, so every
                // load lands in the store.
                if (cmd.op == OP_LOAD)
                    coef_mem[cmd.coef_index] = cmd.coef_value;
                else
                    pending_roots.push_back(predict_root(cmd.start_guess));
            end
            pending_count = pending_roots.size();
        end
    end

endmodule

### sim/polynomial_newton_root_finder_core_tb.sv
// ----------------------------------------------------------------------------
// Polynomial Newton root finder testbench
// Drives coefficient loads, solve words and register writes into the root
// finder under several handshake idling patterns, while a checker module
// predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module polynomial_newton_root_finder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nrf_pkg::*;

    // Fixed-point values that the directed part uses by name.
    localparam logic signed [VALUE_W-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [VALUE_W-1:0] Q_TWO_NEG = 32'shFFFE_0000;
    localparam logic signed [VALUE_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] Q_MIN     = 32'sh8000_0000;

    // The fourth register index has no register behind it; writes to it
    // must leave the block unchanged.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // Idling patterns applied phase by phase.
    localparam int MODE_NONE   = 0;
    localparam int MODE_SENDER = 1;
    localparam int MODE_RECV   = 2;
    localparam int MODE_BOTH   = 3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    nrf_in_if  cmd_ch ();
    nrf_out_if res_ch ();

    int error_count;
    int pending_count;
    int converged_count;
    int limit_count;
    int zero_deriv_count;

    // Percent of cycles in which the sender holds back a word, and in which
    // the receiver refuses a result word.
    int send_idle_pct;
    int recv_stall_pct;

    // Degree in use, as the stimulus needs it to build whole polynomials.
    int active_degree;
    int load_words;
    int solve_words;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    polynomial_newton_root_finder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (cmd_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    nrf_result_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd_ch),
        .res              (res_ch),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .error_count      (error_count),
        .pending_count    (pending_count),
        .converged_count  (converged_count),
        .limit_count      (limit_count),
        .zero_deriv_count (zero_deriv_count)
    );

    // The result side decides its ready at every falling edge, so the block
    // sees a stable value at the next rising edge.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Coefficients are mostly within a few units so that Newton steps behave;
    // one in eight spans the whole 32-bit range to reach the saturation paths.
    function automatic logic signed [VALUE_W-1:0] pick_coef();
        if ($urandom_range(7) == 0)
            return $urandom;
        return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_guess();
        if ($urandom_range(7) == 0)
            return $urandom;
        return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    // Presents one word and returns at the falling edge after it was taken.
    // Valid is left high; whatever runs next lowers it if no word follows.
    task automatic send_word(
        input logic [OP_W-1:0]          op,
        input logic [INDEX_W-1:0]       idx,
        input logic signed [VALUE_W-1:0] value,
        input logic signed [VALUE_W-1:0] guess
    );
        while ($urandom_range(99) < send_idle_pct) begin
            // Idle cycles carry random contents that the block must ignore.
            cmd_ch.valid       = 1'b0;
            cmd_ch.op          = OP_W'($urandom_range(1));
            cmd_ch.coef_index  = INDEX_W'($urandom_range(15));
            cmd_ch.coef_value  = $urandom;
            cmd_ch.start_guess = $urandom;
            @(negedge clk);
        end
        cmd_ch.valid       = 1'b1;
        cmd_ch.op          = op;
        cmd_ch.coef_index  = idx;
        cmd_ch.coef_value  = value;
        cmd_ch.start_guess = guess;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (op == OP_LOAD)
            load_words++;
        else
            solve_words++;
    endtask

    task automatic load_coef(input int idx, input logic signed [VALUE_W-1:0] value);
        send_word(OP_LOAD, idx[INDEX_W-1:0], value, $urandom);
    endtask

    task automatic solve_from(input logic signed [VALUE_W-1:0] guess);
        send_word(OP_SOLVE, INDEX_W'($urandom_range(15)), $urandom, guess);
    endtask

    // Holds the sender back until every solve has returned its result. A
    // load issued after the last solve is taken while the block stays idle,
    // so the further wait leaves the block idle for a register write.
    task automatic wait_idle();
        cmd_ch.valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cmd_ch.valid = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_POLY_DEGREE)
            active_degree = data[DEGREE_W-1:0];
    endtask

    // One block of random traffic under a fresh register setting. Most of
    // it is a full polynomial followed by a few solves; the rest is stray
    // loads into any slot and solves on whatever the store holds.
    task automatic random_block(input int n_items);
        int sent;
        int kind;
        int n_solves;
        sent = 0;
        wait_idle();
        if ($urandom_range(5) == 0)
            write_reg(CFG_POLY_DEGREE, 16'd15);
        else
            write_reg(CFG_POLY_DEGREE,
                      {12'($urandom_range(12'hFFF)), 4'($urandom_range(1, 4))});
        if ($urandom_range(9) == 0)
            write_reg(CFG_ITER_LIMIT, 16'd0);
        else
            write_reg(CFG_ITER_LIMIT, 16'($urandom_range(1, 16)));
        kind = $urandom_range(5);
        if (kind == 0)
            write_reg(CFG_TOLERANCE, 16'd0);
        else if (kind == 1)
            write_reg(CFG_TOLERANCE, 16'hFFFF);
        else
            write_reg(CFG_TOLERANCE, 16'($urandom_range(1, 16'h0400)));
        while (sent < n_items) begin
            kind = $urandom_range(9);
            if (kind < 7) begin
                for (int i = 0; i <= active_degree; i++)
                    load_coef(i, pick_coef());
                n_solves = $urandom_range(1, 3);
                for (int i = 0; i < n_solves; i++)
                    solve_from(pick_guess());
                sent += active_degree + 1 + n_solves;
            end
            else if (kind < 9) begin
                load_coef($urandom_range(15), pick_coef());
                sent++;
            end
            else begin
                solve_from(pick_guess());
                sent++;
            end
        end
    endtask

    initial begin
        logic signed [VALUE_W-1:0] slope;
        cmd_ch.valid       = 1'b0;
        cmd_ch.op          = OP_LOAD;
        cmd_ch.coef_index  = '0;
        cmd_ch.coef_value  = '0;
        cmd_ch.start_guess = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_POLY_DEGREE;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        active_degree  = DEGREE_RESET;
        load_words     = 0;
        solve_words    = 0;
        rst_n          = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. Right after reset the store is all zeros, so the
        // derivative vanishes on the first step.
        solve_from(32'sh0001_8000);

        // x^2 - 2 at degree 2: a clean convergence to the square root of
        // two, a start at zero where the slope is flat, and the two extreme
        // starting points that drive the evaluation into saturation. The
        // degree write carries junk above its four bits.
        wait_idle();
        write_reg(CFG_POLY_DEGREE, 16'hFFF2);
        write_reg(CFG_ITER_LIMIT, 16'd20);
        write_reg(CFG_TOLERANCE, 16'd16);
        load_coef(0, Q_ONE);
        load_coef(1, 32'sh0);
        load_coef(2, Q_TWO_NEG);
        solve_from(Q_ONE);
        solve_from(32'sh0);
        solve_from(Q_MAX);
        solve_from(Q_MIN);

        // Extreme values in the top slots are kept but lie above the degree
        // in use, so the next solve must not see them.
        load_coef(15, Q_MIN);
        load_coef(14, Q_MAX);
        solve_from(-Q_ONE);

        // With a step limit of zero the guess comes straight back.
        wait_idle();
        write_reg(CFG_ITER_LIMIT, 16'd0);
        solve_from(32'sh1234_5678);

        // A zero tolerance can never be met, so the solve runs to the limit.
        wait_idle();
        write_reg(CFG_ITER_LIMIT, 16'd10);
        write_reg(CFG_TOLERANCE, 16'd0);
        solve_from(Q_ONE);

        // Degree zero leaves a constant whose derivative is always zero.
        wait_idle();
        write_reg(CFG_POLY_DEGREE, 16'd0);
        solve_from(32'sh0000_0005);

        // A write to the unused index must change nothing; then the full
        // degree with the extreme top coefficients in play.
        wait_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_POLY_DEGREE, 16'd15);
        write_reg(CFG_ITER_LIMIT, 16'd8);
        write_reg(CFG_TOLERANCE, 16'hFFFF);
        solve_from(32'sh0000_8000);
        solve_from(Q_MIN);

        // Random part: four idling patterns, three register settings each.
        // Every block starts by waiting for all results, which also covers
        // the sender pausing until nothing is outstanding.
        for (int mode = MODE_NONE; mode <= MODE_BOTH; mode++) begin
            case (mode)
                MODE_NONE:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                MODE_SENDER: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                MODE_RECV:   begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default:     begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (int blk = 0; blk < 3; blk++)
                random_block(50);
        end

        // The largest step limit and tolerance. Only straight lines with a
        // root near the origin are solved here, since they settle within two
        // steps and keep the run short.
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_POLY_DEGREE, 16'd1);
        write_reg(CFG_ITER_LIMIT, 16'hFFFF);
        write_reg(CFG_TOLERANCE, 16'hFFFF);
        for (int i = 0; i < 3; i++) begin
            slope = $urandom_range(32'h0001_0000, 32'h0007_FFFF);
            load_coef(0, slope);
            load_coef(1, $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
            solve_from($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
        end

        // Let every outstanding result arrive, then watch a while longer for
        // any stray result word.
        wait_idle();
        repeat (200) @(negedge clk);

        $display("Run covered %0d coefficient loads and %0d solves across four idling patterns.",
                 load_words, solve_words);
        $display("Solve outcomes: %0d converged, %0d hit the step limit, %0d met a flat slope.",
                 converged_count, limit_count, zero_deriv_count);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial begin
        #60_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### polynomial_newton_root_finder_core.f
rtl/core/nrf_pkg.sv
rtl/core/nrf_if.sv
rtl/core/nrf_div.sv
rtl/core/polynomial_newton_root_finder_core.sv
sim/nrf_result_checker.sv
sim/polynomial_newton_root_finder_core_tb.sv
